FILE: design/bfba_pkg.sv
// Shared types and constants for the best-fit block allocator.
package bfba_pkg;
   localparam int MaxBlocksDefault = 64;
   localparam int AddrWidthDefault = 20;
   localparam int SizeWidth = 21;
   localparam int HdrWidth = 8;

   localparam logic [1:0] StOk    = 2'd0;
   localparam logic [1:0] StLimit = 2'd1;
   localparam logic [1:0] StFull  = 2'd2;
   localparam logic [1:0] StBad   = 2'd3;

   localparam logic CsrHeader = 1'b0;
   localparam logic CsrLimit  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_HEAD, S_RD, S_WAIT, S_CHK, S_PICK, S_PICK_WAIT,
      S_SPLIT, S_APPEND, S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic place_head;
      logic walk_start;
      logic rd_issue;
      logic chk;
      logic rd_best;
      logic commit_best;
      logic commit_append;
      logic set_status;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_release;
      logic started;
      logic head_fits;
      logic walk_done;
      logic hit;
      logic rel_bad;
      logic have_best;
      logic append_limit;
      logic table_full;
   } sts_type;
endpackage

FILE: design/bfba_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module bfba_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

FILE: design/bfba_ctrl.sv
// Controller state machine for the allocator.
module bfba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bfba_pkg::sts_type sts,
   output bfba_pkg::cmd_type cmd
);
   import bfba_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_HEAD;
         S_HEAD: begin
            if (sts.is_release) state_in = sts.started ? S_RD : S_RESP;
            else if (!sts.started && !sts.head_fits) state_in = S_RESP;
            else state_in = S_RD;
         end
         S_RD: begin
            if (sts.walk_done) state_in = sts.is_release ? S_RESP : S_PICK;
            else state_in = S_WAIT;
         end
         S_WAIT: state_in = S_CHK;
         S_CHK: state_in = sts.hit ? S_RESP : S_RD;
         S_PICK: state_in = sts.have_best ? S_PICK_WAIT : S_APPEND;
         S_PICK_WAIT: state_in = S_SPLIT;
         S_SPLIT: state_in = S_RESP;
         S_APPEND: state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = StOk;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      case (state_ff)
         S_IDLE: cmd.load = req_valid;
         S_HEAD: begin
            cmd.walk_start = 1'b1;
            if (sts.is_release && !sts.started) begin
               cmd.set_status = 1'b1;
               cmd.status = StBad;
            end else if (!sts.is_release && !sts.started) begin
               if (sts.head_fits) cmd.place_head = 1'b1;
               else begin
                  cmd.set_status = 1'b1;
                  cmd.status = StLimit;
               end
            end
         end
         S_RD: begin
            cmd.rd_issue = !sts.walk_done;
            if (sts.walk_done && sts.is_release) begin
               cmd.set_status = 1'b1;
               cmd.status = StBad;
            end
         end
         S_CHK: begin
            cmd.chk = 1'b1;
            if (sts.hit) begin
               cmd.set_status = 1'b1;
               cmd.status = sts.rel_bad ? StBad : StOk;
            end
         end
         // hold the read address on the best entry until its data is in
         S_PICK, S_PICK_WAIT: cmd.rd_best = 1'b1;
         S_SPLIT: cmd.commit_best = 1'b1;
         S_APPEND: begin
            cmd.set_status = 1'b1;
            if (sts.append_limit) cmd.status = StLimit;
            else if (sts.table_full) cmd.status = StFull;
            else cmd.commit_append = 1'b1;
         end
         default: ;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit_best, cmd.commit_append, cmd.place_head}))
      else $error("conflicting commits");
endmodule

FILE: design/bfba_dpath.sv
// Datapath: block table memory, walk pointer, best-fit tracking, totals.
module bfba_dpath #(
   parameter int MaxBlocks = 64,
   parameter int AddrWidth = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic                             csr_index,
   input  logic [bfba_pkg::SizeWidth-1:0]   csr_data,
   input  logic                             req_action,
   input  logic [bfba_pkg::SizeWidth-1:0]   req_request_size,
   input  logic [AddrWidth-1:0]             req_release_address,
   input  bfba_pkg::cmd_type                cmd,
   output bfba_pkg::sts_type                sts,
   output logic [1:0]                       rsp_status,
   output logic [AddrWidth-1:0]             rsp_address,
   output logic [bfba_pkg::SizeWidth-1:0]   rsp_segment_total,
   output logic [bfba_pkg::SizeWidth-1:0]   rsp_free_total
);
   import bfba_pkg::*;
   localparam int IW = $clog2(MaxBlocks);
   localparam int CW = $clog2(MaxBlocks + 1);
   localparam int WW = SizeWidth + 2 > AddrWidth + 2 ? SizeWidth + 2 : AddrWidth + 2;
   localparam int EW = AddrWidth + SizeWidth + 1 + IW;
   localparam logic [WW-1:0] Span = WW'(1) << AddrWidth;

   logic [HdrWidth-1:0]  hdr_ff;
   logic [SizeWidth-1:0] limit_ff;
   logic                 action_ff;
   logic [SizeWidth-1:0] size_ff;
   logic [AddrWidth-1:0] rel_ff;
   logic [CW-1:0]        used_ff;
   logic [IW-1:0]        last_ff, cur_ff, best_ff, link_ff, head_link_ff;
   logic [SizeWidth-1:0] best_bytes_ff;
   logic                 have_best_ff, started_ff;
   logic [WW-1:0]        heap_end_ff;
   logic [SizeWidth-1:0] app_ff, freed_ff;
   logic [CW-1:0]        step_ff;
   logic [1:0]           status_ff;
   logic [AddrWidth-1:0] addr_ff;

   // table entry: start, bytes, free, link
   logic          we;
   logic [IW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata;
   logic [IW-1:0] rd_ptr;
   bfba_ram #(.Width(EW), .Depth(MaxBlocks)) u_table (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata));

   logic [AddrWidth-1:0] e_start;
   logic [SizeWidth-1:0] e_bytes;
   logic                 e_free;
   logic [IW-1:0]        e_link;
   assign {e_start, e_bytes, e_free, e_link} = rdata;

   logic [WW-1:0] need, lim, rest;
   logic [AddrWidth-1:0] e_payload;
   assign need = WW'(size_ff) + WW'(hdr_ff);
   assign lim = (WW'(limit_ff) < Span) ? WW'(limit_ff) : Span;
   assign e_payload = AddrWidth'(WW'(e_start) + WW'(hdr_ff));
   assign rest = WW'(e_bytes) - need;

   logic fit_ok, exact;
   assign fit_ok = e_free && (WW'(e_bytes) >= need);
   assign exact = WW'(e_bytes) == need;

   // read the successor of the entry last visited
   assign rd_ptr = link_ff;
   always_comb begin
      raddr = rd_ptr;
      if (cmd.rd_best) raddr = best_ff;
   end

   logic split;
   assign split = (rest >= WW'(hdr_ff)) && (used_ff < CW'(MaxBlocks));

   always_comb begin
      sts.is_release = action_ff;
      sts.started = started_ff;
      sts.head_fits = WW'(hdr_ff) <= lim;
      sts.walk_done = (step_ff >= used_ff) || (cur_ff == last_ff);
      sts.hit = action_ff ? (e_payload == rel_ff) : (fit_ok && exact);
      sts.rel_bad = action_ff && e_free;
      sts.have_best = have_best_ff;
      sts.append_limit = heap_end_ff + need > lim;
      sts.table_full = used_ff >= CW'(MaxBlocks);
   end

   logic [IW-1:0] nb;
   assign nb = IW'(used_ff);

   // tail entry as last seen, rewritten with the new link on an append
   logic [EW-1:0] tail_ff;

   // second write: new split block or the old tail's link
   logic [EW-1:0] pend_ff;
   logic [IW-1:0] pend_addr_ff;
   logic          pend_ff_v;

   always_comb begin
      we = 1'b0; waddr = '0; wdata = '0;
      if (cmd.place_head) begin
         we = 1'b1; waddr = '0;
         wdata = {AddrWidth'(0), SizeWidth'(hdr_ff), 1'b0, IW'(0)};
      end else if (cmd.chk && sts.hit) begin
         we = !(action_ff && e_free); waddr = cur_ff;
         wdata = {e_start, e_bytes, action_ff, e_link};
      end else if (cmd.commit_best) begin
         we = 1'b1; waddr = best_ff;
         wdata = split ? {e_start, SizeWidth'(need), 1'b0, nb}
                       : {e_start, e_bytes, 1'b0, e_link};
      end else if (cmd.commit_append) begin
         we = 1'b1; waddr = nb;
         wdata = {AddrWidth'(heap_end_ff), SizeWidth'(need), 1'b0, IW'(0)};
      end else if (pend_ff_v) begin
         we = 1'b1; waddr = pend_addr_ff;
         wdata = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         size_ff <= req_request_size;
         rel_ff <= req_release_address;
         status_ff <= StOk;
         addr_ff <= '0;
      end
      if (cmd.walk_start) begin
         cur_ff <= '0;
         link_ff <= cmd.place_head ? '0 : head_link_ff;
         step_ff <= '0;
         have_best_ff <= 1'b0;
      end
      if (cmd.rd_issue) begin
         cur_ff <= rd_ptr;
         step_ff <= step_ff + CW'(1);
      end
      if (cmd.chk) begin
         link_ff <= (CW'(e_link) < CW'(MaxBlocks)) ? e_link : '0;
         if (!action_ff && fit_ok && !exact &&
             (!have_best_ff || e_bytes < best_bytes_ff)) begin
            have_best_ff <= 1'b1;
            best_ff <= cur_ff;
            best_bytes_ff <= e_bytes;
         end
      end
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.chk && sts.hit && !action_ff) addr_ff <= e_payload;
      if (cmd.commit_best) addr_ff <= e_payload;
      if (cmd.commit_append)
         addr_ff <= AddrWidth'(heap_end_ff + WW'(hdr_ff));
      if (cmd.commit_best && split) begin
         pend_addr_ff <= nb;
         pend_ff <= {AddrWidth'(WW'(e_start) + need), SizeWidth'(rest), 1'b1, e_link};
      end
      if (cmd.commit_append) begin
         pend_addr_ff <= last_ff;
         pend_ff <= {tail_ff[EW-1:IW], nb};
      end

      if (reset) begin
         hdr_ff <= HdrWidth'(40);
         limit_ff <= SizeWidth'(1048576);
         used_ff <= '0;
         last_ff <= '0;
         heap_end_ff <= '0;
         started_ff <= 1'b0;
         app_ff <= '0;
         freed_ff <= '0;
         pend_ff_v <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CsrHeader) hdr_ff <= csr_data[HdrWidth-1:0];
            else limit_ff <= csr_data;
         end
         pend_ff_v <= (cmd.commit_best && split) || cmd.commit_append;
         if (cmd.place_head) begin
            used_ff <= CW'(1);
            last_ff <= '0;
            heap_end_ff <= WW'(hdr_ff);
            started_ff <= 1'b1;
         end
         if (cmd.chk && sts.hit) begin
            if (!action_ff) freed_ff <= freed_ff - e_bytes;
            else if (!e_free) freed_ff <= freed_ff + e_bytes;
         end
         if (cmd.commit_best) begin
            if (split) begin
               used_ff <= used_ff + CW'(1);
               if (last_ff == best_ff) last_ff <= nb;
               freed_ff <= freed_ff - SizeWidth'(need);
            end else freed_ff <= freed_ff - e_bytes;
         end
         if (cmd.commit_append) begin
            used_ff <= used_ff + CW'(1);
            last_ff <= nb;
            heap_end_ff <= heap_end_ff + need;
            app_ff <= app_ff + SizeWidth'(need);
         end
      end
   end

   // an append walks to the tail first, so the tail entry is captured here
   always_ff @(posedge clock) begin
      if (cmd.chk && cur_ff == last_ff) tail_ff <= rdata;
      if (cmd.place_head) begin
         tail_ff <= {AddrWidth'(0), SizeWidth'(hdr_ff), 1'b0, IW'(0)};
         head_link_ff <= '0;
      end
      if (cmd.commit_append && last_ff == '0) head_link_ff <= nb;
   end

   assign rsp_status = status_ff;
   assign rsp_address = (status_ff == StOk && !action_ff) ? addr_ff : '0;
   assign rsp_segment_total = app_ff;
   assign rsp_free_total = freed_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MaxBlocks)) else $error("block count overflow");
   a_head_first: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_append |-> started_ff) else $error("append before head");
   a_last_range: assert property (@(posedge clock) disable iff (reset)
      CW'(last_ff) < used_ff || used_ff == '0) else $error("tail out of table");
endmodule

FILE: design/best_fit_block_allocator_unit.sv
// Top level of the best-fit block allocator.
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | action, request_size, release_address
// rsp     | out       | rsp_valid / rsp_ready | status, address, segment/free totals
// csr     | in        | csr_write             | csr_index, csr_data
// One transaction at a time; an allocate walks the block list entry by entry through
// the table RAM read port. A release stops at its matching entry. Reset is
// synchronous and clears control state; the table needs no clearing. A stalled
// result holds until taken.
module best_fit_block_allocator_unit #(
   parameter int MaxBlocks = bfba_pkg::MaxBlocksDefault,
   parameter int AddrWidth = bfba_pkg::AddrWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [bfba_pkg::SizeWidth-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [bfba_pkg::SizeWidth-1:0] req_request_size,
   input  logic [AddrWidth-1:0]           req_release_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [AddrWidth-1:0]           rsp_address,
   output logic [bfba_pkg::SizeWidth-1:0] rsp_segment_total,
   output logic [bfba_pkg::SizeWidth-1:0] rsp_free_total
);
   import bfba_pkg::*;
   cmd_type cmd;
   sts_type sts;

   bfba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd));

   bfba_dpath #(.MaxBlocks(MaxBlocks), .AddrWidth(AddrWidth)) u_dpath (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_action(req_action),
      .req_request_size(req_request_size),
      .req_release_address(req_release_address), .cmd(cmd), .sts(sts),
      .rsp_status(rsp_status), .rsp_address(rsp_address),
      .rsp_segment_total(rsp_segment_total), .rsp_free_total(rsp_free_total));
endmodule
